// ===== rtl/tllu_pkg.sv =====
// shared types and constants for the trie letter table lookup
// used by tllu_ctrl, tllu_dpath and trie_letter_table_lookup
package tllu_pkg;

  localparam int NODES_DEF    = 1024;
  localparam int ALPHABET_DEF = 26;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK,
    ST_END,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic capture;
    logic walk_eval;
    logic mark_rd;
    logic mark_eval;
    logic finish_direct;
    logic clear_wr;
  } ctrl_t;

  typedef struct packed {
    logic walk_go;
    logic item_last;
    logic held_last;
    logic need_mark;
    logic clear_last;
  } status_t;

endpackage

// ===== rtl/tllu_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module tllu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/tllu_ctrl.sv =====
// controller state machine: clearing pass, letter walk and word end sequencing
// depends on tllu_pkg
module tllu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tllu_pkg::status_t sts,
  output tllu_pkg::ctrl_t   ctl,
  output logic              busy
);

  import tllu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.capture = 1'b1;
          if (sts.walk_go) begin
            state_nxt = ST_LINK;
          end else if (sts.item_last) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_LINK: begin
        ctl.walk_eval = 1'b1;
        state_nxt     = sts.held_last ? ST_END : ST_IDLE;
      end
      ST_END: begin
        if (sts.need_mark) begin
          ctl.mark_rd = 1'b1;
          state_nxt   = ST_MARK;
        end else begin
          ctl.finish_direct = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_MARK: begin
        ctl.mark_eval = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tllu_dpath.sv =====
// datapath: node row memory, walk registers, node allocation and result registers
// depends on tllu_pkg and tllu_ram
module tllu_dpath #(
  parameter int NODES    = tllu_pkg::NODES_DEF,
  parameter int ALPHABET = tllu_pkg::ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_command,
  input  logic [4:0]        in_letter,
  input  logic              in_has_letter,
  input  logic              in_last,
  input  tllu_pkg::ctrl_t   ctl,
  output tllu_pkg::status_t sts,
  output logic              out_valid,
  output logic              out_answer,
  output logic              out_table_full
);

  import tllu_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int UW = NW + 1;
  localparam int RW = ALPHABET * NW + 1;

  logic [1:0]    cmd_r;
  logic [4:0]    letter_r;
  logic          last_r;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic          miss_r, miss_nxt;
  logic          fail_r, fail_nxt;
  logic [NW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          valid_r;
  logic          ans_r, ans_nxt;
  logic          full_r, full_nxt;

  logic          ram_wr_en;
  logic [NW-1:0] ram_wr_addr;
  logic [RW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [RW-1:0] ram_rd_data;

  logic [NW-1:0] sel_link;
  logic [RW-1:0] new_row;
  logic          in_range;
  logic          is_ins;
  logic          is_srch;
  logic          link_null;
  logic          used_full;
  logic          mark_bit;
  logic          finish;
  logic          alloc;

  tllu_ram #(
    .WIDTH(RW),
    .DEPTH(NODES)
  ) u_rows (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(cur_r),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    sel_link = '0;
    new_row  = ram_rd_data;
    for (int i = 0; i < ALPHABET; i++) begin
      if (int'(letter_r) == i) begin
        sel_link             = ram_rd_data[i*NW +: NW];
        new_row[i*NW +: NW]  = used_r[NW-1:0];
      end
    end
  end

  assign in_range  = int'(in_letter) < ALPHABET;
  assign is_ins    = (cmd_r == CMD_INSERT);
  assign is_srch   = (cmd_r == CMD_SEARCH);
  assign link_null = (sel_link == '0);
  assign used_full = (used_r >= UW'(NODES));
  assign alloc     = ctl.walk_eval && link_null && is_ins && !used_full;
  assign mark_bit  = ctl.mark_eval && ram_rd_data[RW-1];
  assign finish    = ctl.mark_eval || ctl.finish_direct;

  assign sts.walk_go    = in_has_letter && !miss_r && !fail_r && in_range;
  assign sts.item_last  = in_last;
  assign sts.held_last  = last_r;
  assign sts.need_mark  = (is_ins && !fail_r && !miss_r) || (is_srch && !miss_r);
  assign sts.clear_last = (clr_cnt_r == NW'(NODES - 1));

  assign ram_rd_en   = (ctl.capture && sts.walk_go) || ctl.mark_rd;
  assign ram_wr_en   = ctl.clear_wr || alloc || (ctl.mark_eval && is_ins);
  assign ram_wr_addr = ctl.clear_wr ? clr_cnt_r : cur_r;

  always_comb begin
    if (ctl.clear_wr) begin
      ram_wr_data = '0;
    end else if (ctl.mark_eval) begin
      ram_wr_data = {1'b1, ram_rd_data[RW-2:0]};
    end else begin
      ram_wr_data = new_row;
    end
  end

  always_comb begin
    cur_nxt     = cur_r;
    used_nxt    = used_r;
    miss_nxt    = miss_r;
    fail_nxt    = fail_r;
    clr_cnt_nxt = clr_cnt_r;
    if (ctl.clear_wr) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
    if (ctl.capture && in_has_letter && !miss_r && !fail_r && !in_range) begin
      miss_nxt = 1'b1;
    end
    if (ctl.walk_eval) begin
      if (!link_null) begin
        cur_nxt = sel_link;
      end else if (!is_ins) begin
        miss_nxt = 1'b1;
      end else if (used_full) begin
        fail_nxt = 1'b1;
      end else begin
        cur_nxt  = used_r[NW-1:0];
        used_nxt = used_r + 1'b1;
      end
    end
    if (finish) begin
      cur_nxt  = '0;
      miss_nxt = 1'b0;
      fail_nxt = 1'b0;
    end
  end

  always_comb begin
    full_nxt = is_ins && fail_r;
    if (is_ins) begin
      ans_nxt = !fail_r && !miss_r;
    end else if (is_srch) begin
      ans_nxt = !miss_r && mark_bit;
    end else begin
      ans_nxt = !miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      used_r    <= UW'(1);
      miss_r    <= 1'b0;
      fail_r    <= 1'b0;
      clr_cnt_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      cur_r     <= cur_nxt;
      used_r    <= used_nxt;
      miss_r    <= miss_nxt;
      fail_r    <= fail_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      valid_r   <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= in_command;
      letter_r <= in_letter;
      last_r   <= in_last;
    end
    if (finish) begin
      ans_r  <= ans_nxt;
      full_r <= full_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_answer     = ans_r;
  assign out_table_full = full_r;

endmodule

// ===== rtl/trie_letter_table_lookup.sv =====
// top level of the trie letter table lookup: controller plus datapath
// depends on tllu_pkg, tllu_ctrl, tllu_dpath
//
// usage:
//   an item (command, letter, has_letter, last) transfers on a rising edge with
//   start high and busy low. words arrive one letter per item; the item with
//   last set closes the word and produces one result on out_answer and
//   out_table_full, marked by out_valid for exactly one cycle. the receiver
//   cannot stall, so a result must be taken in the cycle it is shown.
//   each node is one memory row holding all child links plus its word mark.
//   steps, set by the single row memory and its registered read:
//     letter item, not last: row read, then link follow or node create
//     item with no letter walk, not last: taken in the idle state, no step
//     closing item: a word end step after any letter walk, plus a mark step when the
//       word mark row is read; out_valid rises the cycle after the last step
//   after reset the block clears the node memory one row per cycle, all NODES
//   rows, with busy high; no item transfers until it is done.
module trie_letter_table_lookup #(
  parameter int NODES    = tllu_pkg::NODES_DEF,
  parameter int ALPHABET = tllu_pkg::ALPHABET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  logic [4:0] in_letter,
  input  logic       in_has_letter,
  input  logic       in_last,
  output logic       busy,
  output logic       out_valid,
  output logic       out_answer,
  output logic       out_table_full
);

  import tllu_pkg::*;

  ctrl_t   ctl;
  status_t sts;

  tllu_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy)
  );

  tllu_dpath #(
    .NODES   (NODES),
    .ALPHABET(ALPHABET)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_letter     (in_letter),
    .in_has_letter (in_has_letter),
    .in_last       (in_last),
    .ctl           (ctl),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_answer    (out_answer),
    .out_table_full(out_table_full)
  );

endmodule
